@@ sv/bsa_pkg.sv @@
package bsa_pkg;

    localparam int SLOT_CAPACITY = 256;
    localparam int WORD_BITS     = 64;
    localparam int NUM_WORDS     = (SLOT_CAPACITY + WORD_BITS - 1) / WORD_BITS;
    localparam int WORD_IDX_W    = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
    localparam int BIT_IDX_W     = $clog2(WORD_BITS);

    // Fixed field widths
    localparam int ACTION_W = 2;
    localparam int SLOT_W   = 8;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 9;

    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    localparam logic [APB_ADDR_W-1:0] ADDR_SLOTS_IN_USE = '0;

    typedef logic [WORD_BITS-1:0] word_t;
    typedef logic [COUNT_W-1:0]   count_t;

    typedef enum logic [ACTION_W-1:0] {
        ACT_ALLOC  = 2'd0,
        ACT_FREE   = 2'd1,
        ACT_REINIT = 2'd2,
        ACT_NOP    = 2'd3
    } action_t;

    typedef enum logic [STATUS_W-1:0] {
        STS_OK        = 2'd0,
        STS_EXHAUSTED = 2'd1,
        STS_RANGE     = 2'd2,
        STS_DOUBLE    = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FREE,
        ST_REINIT,
        ST_EMIT
    } state_t;

    // Clamp the raw register value to 1 .. SLOT_CAPACITY
    function automatic count_t managed_count(count_t raw);
        count_t c;
        c = raw;
        if (raw == '0)
            c = count_t'(1);
        else if (raw > count_t'(SLOT_CAPACITY))
            c = count_t'(SLOT_CAPACITY);
        return c;
    endfunction

    // Free mask of word w for a pool of count slots
    function automatic word_t fill_word(count_t count, int w);
        int    rem;
        word_t m;
        rem = int'(count) - w * WORD_BITS;
        if (rem <= 0)
            m = '0;
        else if (rem >= WORD_BITS)
            m = '1;
        else
            m = (word_t'(1) << rem) - word_t'(1);
        return m;
    endfunction

    // Position of the lowest set bit; zero for an empty word
    function automatic logic [BIT_IDX_W-1:0] lowest_bit(word_t word);
        logic [BIT_IDX_W-1:0] pos;
        pos = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--) begin
            if (word[i])
                pos = BIT_IDX_W'(i);
        end
        return pos;
    endfunction

endpackage

@@ sv/bsa_if.sv @@
interface bsa_req_if;
    import bsa_pkg::*;

    logic                valid;
    logic                ready;
    logic [ACTION_W-1:0] action;
    logic [SLOT_W-1:0]   slot_index;

    modport source (output valid, output action, output slot_index, input ready);
    modport sink   (input valid, input action, input slot_index, output ready);
endinterface

interface bsa_rsp_if;
    import bsa_pkg::*;

    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   granted_index;
    logic [COUNT_W-1:0]  free_count;
    logic                all_free;
    logic                none_free;

    modport source (
        output valid, output status, output granted_index, output free_count,
        output all_free, output none_free, input ready
    );
    modport sink (
        input valid, input status, input granted_index, input free_count,
        input all_free, input none_free, output ready
    );
endinterface

@@ sv/bitmap_slot_allocator_core.sv @@
// Slot allocator for one pool of up to 256 slots, tracked by a free bitmap of four
// 64-bit words (bit set = slot free). An allocate item returns the lowest free slot,
// a free item returns a slot to the pool (out-of-range and double frees are reported
// and change nothing), and a reinit item marks every managed slot free. Each item
// gives one result with the free count and the all-free / none-free flags. The block
// takes one item at a time: req.ready is high only while idle. An allocate examines
// the bitmap words in turn through the shared word read and priority encoder, and
// goes through accept, a scan of one word after another until a free slot or the last
// word, and result load; free and reinit go through accept, update and result load,
// and the unused action 3 through accept and result load. The result register lets
// the next item be accepted while the previous result still waits on rsp.ready; a new
// result that finds the register still full holds in the result state until it is free.
// Writing slots_in_use over APB (address 0) reinitializes the pool at once with the
// new count, clamped to 1 .. 256; reads return the raw register value.
module bitmap_slot_allocator_core (
    input  logic                           clk,
    input  logic                           rst_n,
    bsa_req_if.sink                        req,
    bsa_rsp_if.source                      rsp,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [bsa_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [bsa_pkg::APB_DATA_W-1:0] pwdata,
    output logic [bsa_pkg::APB_DATA_W-1:0] prdata,
    output logic                           pready
);
    import bsa_pkg::*;

    localparam logic [WORD_IDX_W-1:0] LAST_WORD = WORD_IDX_W'(NUM_WORDS - 1);

    state_t                state_reg, state_next;
    count_t                slots_reg, slots_next;
    count_t                count_eff;
    word_t                 bitmap_reg  [NUM_WORDS];
    word_t                 bitmap_next [NUM_WORDS];
    count_t                free_slots_reg, free_slots_next;
    logic [WORD_IDX_W-1:0] scan_idx_reg, scan_idx_next;
    logic [SLOT_W-1:0]     slot_reg, slot_next;
    status_t               res_status_reg, res_status_next;
    logic [SLOT_W-1:0]     res_grant_reg, res_grant_next;

    logic                  rsp_valid_reg, rsp_valid_next;
    status_t               rsp_status_reg;
    logic [SLOT_W-1:0]     rsp_grant_reg;
    count_t                rsp_count_reg;
    logic                  rsp_all_reg;
    logic                  rsp_none_reg;

    logic                  out_free;
    logic                  emit_load;
    logic                  cfg_write;
    count_t                cfg_count;
    logic [WORD_IDX_W-1:0] word_sel;
    word_t                 cur_word;
    logic                  word_nz;
    logic [BIT_IDX_W-1:0]  low_bit;
    logic [BIT_IDX_W-1:0]  slot_bit;

    // ------------------------------------------------------------------
    // Handshakes and the configuration port
    // ------------------------------------------------------------------
    assign count_eff  = managed_count(slots_reg);
    assign out_free   = !rsp_valid_reg || rsp.ready;
    assign emit_load  = (state_reg == ST_EMIT) && out_free;

    assign cfg_write  = psel && penable && pwrite && (paddr == ADDR_SLOTS_IN_USE);
    assign cfg_count  = managed_count(pwdata[COUNT_W-1:0]);
    assign pready     = 1'b1;
    assign prdata     = (paddr == ADDR_SLOTS_IN_USE) ? APB_DATA_W'(slots_reg) : '0;

    // ------------------------------------------------------------------
    // Shared word read and priority encoder: the scan index during an
    // allocate, the word of the requested slot during a free
    // ------------------------------------------------------------------
    assign word_sel = (state_reg == ST_SCAN) ? scan_idx_reg
                                             : slot_reg[BIT_IDX_W +: WORD_IDX_W];
    assign slot_bit = slot_reg[BIT_IDX_W-1:0];
    assign cur_word = bitmap_reg[word_sel];
    assign word_nz  = |cur_word;
    assign low_bit  = lowest_bit(cur_word);

    // ------------------------------------------------------------------
    // Sequencer: next state
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    unique case (action_t'(req.action))
                        ACT_ALLOC:  state_next = ST_SCAN;
                        ACT_FREE:   state_next = ST_FREE;
                        ACT_REINIT: state_next = ST_REINIT;
                        ACT_NOP:    state_next = ST_EMIT;
                        default:    state_next = ST_EMIT;
                    endcase
                end
            end
            ST_SCAN:
            begin
                if (word_nz || (scan_idx_reg == LAST_WORD))
                    state_next = ST_EMIT;
            end
            ST_FREE:   state_next = ST_EMIT;
            ST_REINIT: state_next = ST_EMIT;
            ST_EMIT:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // Sequencer: outputs and datapath updates
    // ------------------------------------------------------------------
    always_comb
    begin
        req.ready       = 1'b0;
        bitmap_next     = bitmap_reg;
        free_slots_next = free_slots_reg;
        scan_idx_next   = scan_idx_reg;
        slot_next       = slot_reg;
        res_status_next = res_status_reg;
        res_grant_next  = res_grant_reg;
        slots_next      = slots_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                req.ready = 1'b1;
                if (req.valid)
                begin
                    slot_next       = req.slot_index;
                    scan_idx_next   = '0;
                    res_status_next = STS_OK;
                    res_grant_next  = '0;
                end
            end
            ST_SCAN:
            begin
                if (word_nz)
                begin
                    // Take the lowest free slot of this word
                    bitmap_next[word_sel] = cur_word & ~(word_t'(1) << low_bit);
                    res_grant_next        = SLOT_W'({scan_idx_reg, low_bit});
                    if (free_slots_reg != '0)
                        free_slots_next = free_slots_reg - count_t'(1);
                end
                else if (scan_idx_reg == LAST_WORD)
                begin
                    res_status_next = STS_EXHAUSTED;
                end
                else
                begin
                    scan_idx_next = scan_idx_reg + WORD_IDX_W'(1);
                end
            end
            ST_FREE:
            begin
                if (count_t'(slot_reg) >= count_eff)
                    res_status_next = STS_RANGE;
                else if (cur_word[slot_bit])
                    res_status_next = STS_DOUBLE;
                else
                begin
                    bitmap_next[word_sel] = cur_word | (word_t'(1) << slot_bit);
                    free_slots_next       = free_slots_reg + count_t'(1);
                end
            end
            ST_REINIT:
            begin
                for (int w = 0; w < NUM_WORDS; w++)
                    bitmap_next[w] = fill_word(count_eff, w);
                free_slots_next = count_eff;
            end
            ST_EMIT:
            begin
                // Results are loaded into the output register below
            end
            default:
            begin
            end
        endcase

        // A register write rebuilds the pool with the new count
        if (cfg_write)
        begin
            slots_next = pwdata[COUNT_W-1:0];
            for (int w = 0; w < NUM_WORDS; w++)
                bitmap_next[w] = fill_word(cfg_count, w);
            free_slots_next = cfg_count;
        end
    end

    // Output register: hold until taken, load on the result state
    always_comb
    begin
        rsp_valid_next = rsp_valid_reg && !rsp.ready;
        if (emit_load)
            rsp_valid_next = 1'b1;
    end

    assign rsp.valid         = rsp_valid_reg;
    assign rsp.status        = rsp_status_reg;
    assign rsp.granted_index = rsp_grant_reg;
    assign rsp.free_count    = rsp_count_reg;
    assign rsp.all_free      = rsp_all_reg;
    assign rsp.none_free     = rsp_none_reg;

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            rsp_valid_reg  <= 1'b0;
            slots_reg      <= count_t'(SLOT_CAPACITY);
            free_slots_reg <= count_t'(SLOT_CAPACITY);
            for (int w = 0; w < NUM_WORDS; w++)
                bitmap_reg[w] <= fill_word(count_t'(SLOT_CAPACITY), w);
        end
        else
        begin
            state_reg      <= state_next;
            rsp_valid_reg  <= rsp_valid_next;
            slots_reg      <= slots_next;
            free_slots_reg <= free_slots_next;
            for (int w = 0; w < NUM_WORDS; w++)
                bitmap_reg[w] <= bitmap_next[w];
        end
    end

    always_ff @(posedge clk)
    begin
        scan_idx_reg   <= scan_idx_next;
        slot_reg       <= slot_next;
        res_status_reg <= res_status_next;
        res_grant_reg  <= res_grant_next;
        if (emit_load)
        begin
            rsp_status_reg <= res_status_reg;
            rsp_grant_reg  <= res_grant_reg;
            rsp_count_reg  <= free_slots_reg;
            rsp_all_reg    <= (free_slots_reg == count_eff);
            rsp_none_reg   <= (free_slots_reg == '0);
        end
    end

`ifndef SYNTH
    // The free count never exceeds the managed slot count
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        free_slots_reg <= count_eff)
        else $error("free count above managed slot count");

    // An accepted item always starts work
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |=> (state_reg != ST_IDLE))
        else $error("sequencer idle after accepting an item");

    // A failed request always carries a zero slot index
    a_grant_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && (rsp.status != STS_OK)) |-> (rsp.granted_index == '0))
        else $error("granted index set on a failed request");

    // A pool of at least one slot cannot be both full and empty
    a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid |-> !(rsp.all_free && rsp.none_free))
        else $error("all_free and none_free both set");
`endif

endmodule
